// ===== rtl/rab_pkg.sv =====
package rab_pkg;

    localparam int DataW    = 32;
    localparam int RegAddrW = 4;
    localparam int NumRegs  = 16;
    localparam int OpW      = 5;
    localparam int OffsetW  = 24;

    localparam logic [RegAddrW-1:0] PcIndex   = 4'd15;
    localparam logic [RegAddrW-1:0] LinkIndex = 4'd14;

    // opcode map, data operations in classic order then the two branches
    typedef enum logic [OpW-1:0] {
        OP_AND = 5'd0,
        OP_EOR = 5'd1,
        OP_SUB = 5'd2,
        OP_RSB = 5'd3,
        OP_ADD = 5'd4,
        OP_ADC = 5'd5,
        OP_SBC = 5'd6,
        OP_RSC = 5'd7,
        OP_TST = 5'd8,
        OP_TEQ = 5'd9,
        OP_CMP = 5'd10,
        OP_CMN = 5'd11,
        OP_ORR = 5'd12,
        OP_MOV = 5'd13,
        OP_BIC = 5'd14,
        OP_MVN = 5'd15,
        OP_B   = 5'd16,
        OP_BL  = 5'd17
    } op_t;

    // instruction class chosen by the front end
    typedef enum logic [1:0] {
        KIND_NOP    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FLAG   = 2'd2,
        KIND_BRANCH = 2'd3
    } kind_t;

    typedef struct packed {
        logic [OpW-1:0]      op;
        logic [RegAddrW-1:0] dest_reg;
        logic [RegAddrW-1:0] first_reg;
        logic [DataW-1:0]    operand_two;
        logic                use_immediate;
    } cmd_t;

    typedef struct packed {
        logic                reg_written;
        logic [RegAddrW-1:0] written_index;
        logic [DataW-1:0]    written_value;
        logic                flag_negative;
        logic                flag_zero;
        logic                flag_carry;
        logic                flag_overflow;
        logic [DataW-1:0]    program_counter;
    } res_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // decoded instruction as it travels through the queue
    typedef struct packed {
        op_t                 op;
        kind_t               kind;
        logic                link;
        logic [RegAddrW-1:0] dest_reg;
        logic [RegAddrW-1:0] first_reg;
        logic [RegAddrW-1:0] second_reg;
        logic [DataW-1:0]    operand_two;
        logic                use_immediate;
    } dec_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        dec_t item;
    } qhead_t;

endpackage

// ===== rtl/rab_if.sv =====
interface rab_cmd_if
    import rab_pkg::*;
;
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rab_res_if
    import rab_pkg::*;
;
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/register_alu_with_flags_and_branch.sv =====
// a result is registered after the queue and the register read stage
// throughput: one instruction per cycle while results are taken; the two-entry
// queue, the register read stage and the result register together hold up to
// four instructions, the register file has two read ports
// reset: asynchronous, active low; marks every register invalid so it reads as zero,
// clears the flags, the program counter, the queue and all valid state
module register_alu_with_flags_and_branch
    import rab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rab_cmd_if.sink   cmd,
    rab_res_if.source res
);

    qhead_t head;
    logic   pop;

    // decode and queue
    rab_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .pop   (pop)
    );

    // register read, execute and result register
    rab_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

// ===== rtl/rab_front.sv =====
module rab_front
    import rab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rab_cmd_if.sink   cmd,
    output qhead_t    head,
    input  logic      pop
);

    localparam int Depth = 2;

    dec_t       queue_reg [Depth];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       do_pop;
    dec_t       decoded;

    // classify the incoming instruction
    always_comb
    begin
        decoded.op            = op_t'(cmd.data.op);
        decoded.link          = (cmd.data.op == OP_BL);
        decoded.dest_reg      = cmd.data.dest_reg;
        decoded.first_reg     = cmd.data.first_reg;
        decoded.second_reg    = cmd.data.operand_two[RegAddrW-1:0];
        decoded.operand_two   = cmd.data.operand_two;
        decoded.use_immediate = cmd.data.use_immediate;
        if (cmd.data.op == OP_TST || cmd.data.op == OP_TEQ ||
            cmd.data.op == OP_CMP || cmd.data.op == OP_CMN)
        begin
            decoded.kind = KIND_FLAG;
        end
        else if (cmd.data.op == OP_B || cmd.data.op == OP_BL)
        begin
            decoded.kind = KIND_BRANCH;
        end
        else if (cmd.data.op <= OP_MVN)
        begin
            decoded.kind = KIND_DATA;
        end
        else
        begin
            decoded.kind = KIND_NOP;
        end
    end

    // queue control
    assign cmd.ready   = (count_reg != 2'(Depth));
    assign push        = cmd.valid && cmd.ready;
    assign do_pop      = pop && (count_reg != 2'd0);
    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/rab_back.sv =====
module rab_back
    import rab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  qhead_t    head,
    output logic      pop,
    rab_res_if.source res
);

    logic [DataW-1:0]   mem [NumRegs];
    logic [NumRegs-1:0] valid_reg;

    // read stage registers
    logic               vb_reg;
    dec_t               item_reg;
    logic [DataW-1:0]   mem_a_reg;
    logic [DataW-1:0]   mem_b_reg;
    logic [DataW-1:0]   byp_a_reg;
    logic [DataW-1:0]   byp_b_reg;
    logic               hit_a_reg;
    logic               hit_b_reg;
    logic               vld_a_reg;
    logic               vld_b_reg;

    logic [DataW-1:0]   pc_reg;
    logic [DataW-1:0]   pc_next;
    flags_t             flags_reg;
    flags_t             flags_next;
    logic               out_valid_reg;
    res_t               out_data_reg;

    logic               adv;
    logic               exec_fire;
    logic [DataW-1:0]   a;
    logic [DataW-1:0]   b_reg_val;
    logic [DataW-1:0]   b;
    logic [DataW-1:0]   cin;
    logic [DataW-1:0]   alu_res;
    logic [DataW:0]     cmn_sum;
    logic [DataW-1:0]   teq_val;
    logic [DataW-1:0]   cmp_val;
    logic [DataW-1:0]   offset;
    logic [DataW-1:0]   target;
    flags_t             flags_new;
    logic               pc_we;
    logic [DataW-1:0]   pc_new;
    logic               mem_we;
    logic [RegAddrW-1:0] mem_wa;
    logic [DataW-1:0]   mem_wd;
    res_t               result;
    logic [RegAddrW-1:0] ra;
    logic [RegAddrW-1:0] rb;
    logic               hit_a;
    logic               hit_b;
    logic [DataW-1:0]   byp_a;
    logic [DataW-1:0]   byp_b;

    // pipeline advances unless a finished result is still waiting
    assign adv       = !out_valid_reg || res.ready;
    assign pop       = adv;
    assign exec_fire = adv && vb_reg;

    // operand selection with write bypass
    assign a         = hit_a_reg ? byp_a_reg : (vld_a_reg ? mem_a_reg : '0);
    assign b_reg_val = hit_b_reg ? byp_b_reg : (vld_b_reg ? mem_b_reg : '0);
    assign b         = item_reg.use_immediate ? item_reg.operand_two : b_reg_val;
    assign cin       = {{(DataW-1){1'b0}}, flags_reg.c};

    assign cmn_sum   = {1'b0, a} + {1'b0, b};
    assign teq_val   = a ^ b;
    assign cmp_val   = a - b;
    assign offset    = {{(DataW-OffsetW){item_reg.operand_two[OffsetW-1]}},
                        item_reg.operand_two[OffsetW-1:0]};
    assign target    = pc_reg + offset;

    // data operation result
    always_comb
    begin
        unique case (item_reg.op)
            OP_AND:  alu_res = a & b;
            OP_EOR:  alu_res = a ^ b;
            OP_SUB:  alu_res = a - b;
            OP_RSB:  alu_res = b - a;
            OP_ADD:  alu_res = a + b;
            OP_ADC:  alu_res = a + b + cin;
            OP_SBC:  alu_res = a - b - cin;
            OP_RSC:  alu_res = b - a - cin;
            OP_ORR:  alu_res = a | b;
            OP_MOV:  alu_res = b;
            OP_BIC:  alu_res = a & ~b;
            OP_MVN:  alu_res = ~b;
            default: alu_res = '0;
        endcase
    end

    // flag update for compare and test operations
    always_comb
    begin
        flags_new = flags_reg;
        unique case (item_reg.op)
            OP_TST:
            begin
                flags_new.z = ((a & b) == '0);
            end
            OP_TEQ:
            begin
                flags_new = '{n: teq_val[DataW-1], z: (teq_val == '0), c: 1'b0, v: 1'b0};
            end
            OP_CMP:
            begin
                flags_new = '{n: cmp_val[DataW-1], z: (cmp_val == '0), c: 1'b0, v: 1'b0};
            end
            OP_CMN:
            begin
                if (cmn_sum[DataW])
                begin
                    flags_new = '{n: 1'b0, z: 1'b0, c: 1'b0, v: 1'b1};
                end
                else
                begin
                    flags_new = '{n: cmn_sum[DataW-1], z: (cmn_sum[DataW-1:0] == '0),
                                  c: 1'b0, v: 1'b0};
                end
            end
            default: flags_new = flags_reg;
        endcase
    end

    assign flags_next = (exec_fire && item_reg.kind == KIND_FLAG) ? flags_new : flags_reg;

    // state writes and result fields
    always_comb
    begin
        pc_we  = 1'b0;
        pc_new = pc_reg;
        mem_we = 1'b0;
        mem_wa = item_reg.dest_reg;
        mem_wd = alu_res;
        result.reg_written   = 1'b0;
        result.written_index = '0;
        result.written_value = '0;
        unique case (item_reg.kind)
            KIND_DATA:
            begin
                result.reg_written   = 1'b1;
                result.written_index = item_reg.dest_reg;
                result.written_value = alu_res;
                if (item_reg.dest_reg == PcIndex)
                begin
                    pc_we  = 1'b1;
                    pc_new = alu_res;
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            KIND_BRANCH:
            begin
                pc_we              = 1'b1;
                pc_new             = target;
                result.reg_written = 1'b1;
                if (item_reg.link)
                begin
                    mem_we               = 1'b1;
                    mem_wa               = LinkIndex;
                    mem_wd               = pc_reg;
                    result.written_index = LinkIndex;
                    result.written_value = pc_reg;
                end
                else
                begin
                    result.written_index = PcIndex;
                    result.written_value = target;
                end
            end
            default:
            begin
                pc_we = 1'b0;
            end
        endcase
        result.flag_negative   = flags_next.n;
        result.flag_zero       = flags_next.z;
        result.flag_carry      = flags_next.c;
        result.flag_overflow   = flags_next.v;
        result.program_counter = pc_new;
    end

    assign pc_next = (exec_fire && pc_we) ? pc_new : pc_reg;

    // read addresses and same-cycle write bypass
    assign ra    = head.item.first_reg;
    assign rb    = head.item.second_reg;
    assign hit_a = (ra == PcIndex) || (exec_fire && mem_we && mem_wa == ra);
    assign hit_b = (rb == PcIndex) || (exec_fire && mem_we && mem_wa == rb);
    assign byp_a = (ra == PcIndex) ? pc_next : mem_wd;
    assign byp_b = (rb == PcIndex) ? pc_next : mem_wd;

    // register file memory
    always_ff @(posedge clk)
    begin
        if (exec_fire && mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (adv)
        begin
            mem_a_reg <= mem[ra];
            mem_b_reg <= mem[rb];
            byp_a_reg <= byp_a;
            byp_b_reg <= byp_b;
            hit_a_reg <= hit_a;
            hit_b_reg <= hit_b;
            vld_a_reg <= valid_reg[ra];
            vld_b_reg <= valid_reg[rb];
            item_reg  <= head.item;
        end
        if (exec_fire)
        begin
            out_data_reg <= result;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            vb_reg        <= 1'b0;
            pc_reg        <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            flags_reg <= flags_next;
            if (exec_fire && mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            if (adv)
            begin
                vb_reg        <= head.valid;
                out_valid_reg <= vb_reg;
            end
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

endmodule

// ===== sim/register_alu_with_flags_and_branch_checker.sv =====
module register_alu_with_flags_and_branch_checker
    import rab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rab_cmd_if          cmd,
    rab_res_if          res,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxPrinted = 40;

    // shadow architectural state
    logic [DataW-1:0] reg_bank [NumRegs];
    flags_t           status;

    // predicted results, oldest first
    res_t             expected_q [$];
    res_t             want;
    int unsigned      mismatches;
    int unsigned      results_seen;

    task automatic report_mismatch(input string what);
        if (mismatches < MaxPrinted)
            $display("mismatch at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [DataW-1:0] got,
                               input logic [DataW-1:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %h, predicted %h", name, got, exp_val));
    endtask

    function automatic flags_t nz_of(input logic [DataW-1:0] v);
        flags_t f;
        f   = '0;
        f.n = v[DataW-1];
        f.z = (v == '0);
        return f;
    endfunction

    // execute one instruction on the shadow state and build its result
    function automatic res_t execute_instr(input cmd_t c);
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] value;
        logic [DataW-1:0] offset;
        logic [DataW-1:0] old_pc;
        logic [DataW:0]   wide;
        logic [DataW-1:0] cin;
        logic             writes;
        res_t             r;

        a      = reg_bank[c.first_reg];
        b      = c.use_immediate ? c.operand_two : reg_bank[c.operand_two[RegAddrW-1:0]];
        cin    = {{(DataW-1){1'b0}}, status.c};
        value  = '0;
        writes = 1'b1;
        r      = '0;

        case (c.op)
            OP_AND: value = a & b;
            OP_EOR: value = a ^ b;
            OP_SUB: value = a - b;
            OP_RSB: value = b - a;
            OP_ADD: value = a + b;
            OP_ADC: value = a + b + cin;
            OP_SBC: value = a - b - cin;
            OP_RSC: value = b - a - cin;
            OP_ORR: value = a | b;
            OP_MOV: value = b;
            OP_BIC: value = a & ~b;
            OP_MVN: value = ~b;
            // test only touches zero
            OP_TST:
            begin
                writes   = 1'b0;
                status.z = ((a & b) == '0);
            end
            OP_TEQ:
            begin
                writes = 1'b0;
                status = nz_of(a ^ b);
            end
            OP_CMP:
            begin
                writes = 1'b0;
                status = nz_of(a - b);
            end
            // carry out of bit 31 shows up as overflow alone
            OP_CMN:
            begin
                writes = 1'b0;
                wide   = {1'b0, a} + {1'b0, b};
                if (wide[DataW])
                begin
                    status   = '0;
                    status.v = 1'b1;
                end
                else
                    status = nz_of(wide[DataW-1:0]);
            end
            // branches report their own register write
            OP_B, OP_BL:
            begin
                writes = 1'b0;
                offset = {{(DataW-OffsetW){c.operand_two[OffsetW-1]}},
                          c.operand_two[OffsetW-1:0]};
                old_pc = reg_bank[PcIndex];
                reg_bank[PcIndex] = old_pc + offset;
                r.reg_written = 1'b1;
                if (c.op == OP_BL)
                begin
                    reg_bank[LinkIndex] = old_pc;
                    r.written_index     = LinkIndex;
                    r.written_value     = old_pc;
                end
                else
                begin
                    r.written_index = PcIndex;
                    r.written_value = reg_bank[PcIndex];
                end
            end
            default: writes = 1'b0;
        endcase

        if (writes)
        begin
            reg_bank[c.dest_reg] = value;
            r.reg_written        = 1'b1;
            r.written_index      = c.dest_reg;
            r.written_value      = value;
        end

        r.flag_negative   = status.n;
        r.flag_zero       = status.z;
        r.flag_carry      = status.c;
        r.flag_overflow   = status.v;
        r.program_counter = reg_bank[PcIndex];
        return r;
    endfunction

    // watch both channels, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumRegs; i++)
                reg_bank[i] = '0;
            status = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // result transaction: compare with the oldest prediction
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch("result with no instruction outstanding");
                else
                begin
                    want = expected_q.pop_front();
                    check_field("reg_written", DataW'(res.data.reg_written),
                                DataW'(want.reg_written));
                    check_field("written_index", DataW'(res.data.written_index),
                                DataW'(want.written_index));
                    check_field("written_value", res.data.written_value, want.written_value);
                    check_field("flag_negative", DataW'(res.data.flag_negative),
                                DataW'(want.flag_negative));
                    check_field("flag_zero", DataW'(res.data.flag_zero),
                                DataW'(want.flag_zero));
                    check_field("flag_carry", DataW'(res.data.flag_carry),
                                DataW'(want.flag_carry));
                    check_field("flag_overflow", DataW'(res.data.flag_overflow),
                                DataW'(want.flag_overflow));
                    check_field("program_counter", res.data.program_counter,
                                want.program_counter);
                end
            end

            // instruction transaction: run it on the shadow state
            if (cmd.valid && cmd.ready)
                expected_q.push_back(execute_instr(cmd.data));

            pending <= expected_q.size();
        end
        fail_count <= mismatches;
        checked    <= results_seen;
    end

endmodule

// ===== sim/register_alu_with_flags_and_branch_tb.sv =====
module register_alu_with_flags_and_branch_tb;
    import rab_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems    = 1925;
    localparam int LongHoldAt     = 300;
    localparam int LongHoldCycles = 80;
    localparam int SteadyWindow   = 40;
    localparam int PauseAt        = 1000;
    localparam int DrainCycles    = 8;

    localparam logic [OpW-1:0] OpUnusedLo = 5'd18;
    localparam logic [OpW-1:0] OpUnusedHi = 5'd31;

    logic clk;
    logic rst_n;

    rab_cmd_if cmd_ch ();
    rab_res_if res_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    int unsigned issued;
    int unsigned branch_count;
    int unsigned flag_op_count;
    int unsigned unused_count;
    int unsigned burst_left;
    logic        long_hold_done;

    register_alu_with_flags_and_branch dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    register_alu_with_flags_and_branch_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic cmd_t mk(input logic [OpW-1:0] op, input logic [RegAddrW-1:0] rd,
                                input logic [RegAddrW-1:0] rn,
                                input logic [DataW-1:0] op2, input logic imm);
        cmd_t c;
        c.op            = op;
        c.dest_reg      = rd;
        c.first_reg     = rn;
        c.operand_two   = op2;
        c.use_immediate = imm;
        return c;
    endfunction

    // mostly data ops, some branches, a few unused opcodes
    function automatic cmd_t random_instr();
        cmd_t        c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            c.op = OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
        else if (pick < 18)
            c.op = pick[0] ? OP_BL : OP_B;
        else
            c.op = OpW'($urandom_range(OP_AND, OP_MVN));
        c.dest_reg      = RegAddrW'($urandom);
        c.first_reg     = RegAddrW'($urandom);
        c.use_immediate = 1'($urandom);
        case ($urandom_range(0, 9))
            5, 6:    c.operand_two = $urandom_range(0, 15);
            7, 8, 9:
            begin
                case ($urandom_range(0, 4))
                    0:       c.operand_two = 32'h0000_0000;
                    1:       c.operand_two = 32'h0000_0001;
                    2:       c.operand_two = 32'h7FFF_FFFF;
                    3:       c.operand_two = 32'h8000_0000;
                    default: c.operand_two = 32'hFFFF_FFFF;
                endcase
            end
            default: c.operand_two = $urandom;
        endcase
        return c;
    endfunction

    // offer one instruction and hold it until the transaction completes
    task automatic issue(input cmd_t c);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        issued++;
        if (c.op == OP_B || c.op == OP_BL)
            branch_count++;
        else if (c.op >= OP_TST && c.op <= OP_CMN)
            flag_op_count++;
        else if (c.op > OP_BL)
            unused_count++;
    endtask

    // bursts of random length separated by random gaps, none in the steady window
    task automatic pace();
        int unsigned gap;
        gap = 0;
        if (issued >= LongHoldAt && issued < LongHoldAt + SteadyWindow)
            gap = 0;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: changing stall patterns plus one long hold-off
    initial
    begin : receiver
        int unsigned cyc;
        int unsigned mode;
        logic [7:0]  mask;
        cyc  = 0;
        mode = 0;
        mask = 8'hFF;
        long_hold_done = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && issued >= LongHoldAt)
            begin
                long_hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge clk);
            end
            else
            begin
                if (cyc % 64 == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    mask    = 8'($urandom);
                    mask[0] = 1'b1;
                end
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom);
                    2:       res_ch.ready <= mask[cyc % 8];
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
                cyc++;
                @(posedge clk);
            end
        end
    end

    // hard limit on run length
    initial
    begin
        #1_000_000;
        $display("register_alu_with_flags_and_branch regression: fail");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        cmd_t directed_q [$];

        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        issued         = 0;
        branch_count   = 0;
        flag_op_count  = 0;
        unused_count   = 0;
        burst_left     = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: operand extremes, every opcode, flag corner cases, branches
        directed_q.push_back(mk(OP_MOV, 4'd1, 4'd0, 32'hFFFF_FFFF, 1'b1));
        directed_q.push_back(mk(OP_MOV, 4'd2, 4'd0, 32'h8000_0000, 1'b1));
        directed_q.push_back(mk(OP_MVN, 4'd3, 4'd0, 32'hFFFF_FFFF, 1'b1));
        // register operand named by low bits only, upper bits set
        directed_q.push_back(mk(OP_ADD, 4'd4, 4'd1, 32'hFFFF_FFF1, 1'b0));
        directed_q.push_back(mk(OP_SUB, 4'd5, 4'd3, 32'h0000_0001, 1'b1));
        directed_q.push_back(mk(OP_RSB, 4'd6, 4'd2, 32'h0000_0001, 1'b0));
        directed_q.push_back(mk(OP_ADC, 4'd7, 4'd1, 32'h0000_0001, 1'b1));
        directed_q.push_back(mk(OP_SBC, 4'd8, 4'd3, 32'h0000_0000, 1'b1));
        directed_q.push_back(mk(OP_RSC, 4'd9, 4'd1, 32'h0000_0000, 1'b1));
        directed_q.push_back(mk(OP_AND, 4'd10, 4'd1, 32'h0000_0002, 1'b0));
        directed_q.push_back(mk(OP_EOR, 4'd11, 4'd1, 32'h0000_0002, 1'b0));
        directed_q.push_back(mk(OP_ORR, 4'd12, 4'd3, 32'h0000_0000, 1'b1));
        directed_q.push_back(mk(OP_BIC, 4'd13, 4'd1, 32'h0000_0002, 1'b0));
        // test with zero result, test-equal negative, compare equal
        directed_q.push_back(mk(OP_TST, 4'd0, 4'd3, 32'h0000_0001, 1'b0));
        directed_q.push_back(mk(OP_TEQ, 4'd0, 4'd1, 32'h0000_0003, 1'b0));
        directed_q.push_back(mk(OP_CMP, 4'd0, 4'd2, 32'h8000_0000, 1'b1));
        // compare-negative with and without carry out
        directed_q.push_back(mk(OP_CMN, 4'd0, 4'd1, 32'h0000_0001, 1'b1));
        directed_q.push_back(mk(OP_CMN, 4'd0, 4'd3, 32'h0000_0000, 1'b1));
        // data op into the program counter
        directed_q.push_back(mk(OP_MOV, PcIndex, 4'd0, 32'h0000_1000, 1'b1));
        // most negative and most positive offsets, upper bits ignored
        directed_q.push_back(mk(OP_B, 4'd3, 4'd5, 32'hFF80_0000, 1'b0));
        directed_q.push_back(mk(OP_B, 4'd0, 4'd0, 32'h007F_FFFF, 1'b1));
        directed_q.push_back(mk(OP_BL, 4'd7, 4'd9, 32'hAB00_0010, 1'b0));
        // unused opcodes change nothing
        directed_q.push_back(mk(OpUnusedHi, 4'd1, 4'd1, 32'hFFFF_FFFF, 1'b1));
        directed_q.push_back(mk(OpUnusedLo, 4'd2, 4'd2, 32'h0000_0000, 1'b0));
        directed_q.push_back(mk(OP_MOV, 4'd0, 4'd0, 32'h0000_000E, 1'b0));

        foreach (directed_q[i])
        begin
            issue(directed_q[i]);
            pace();
        end

        // random instruction stream
        repeat (RandomItems)
        begin
            issue(random_instr());
            // one full drain with the sender idle
            if (issued == PauseAt)
            begin
                cmd_ch.valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            pace();
        end

        // drain everything still in flight
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d instructions: %0d branches, %0d flag updates, %0d unused opcodes",
                 issued, branch_count, flag_op_count, unused_count);
        $display("%0d results compared field by field, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("register_alu_with_flags_and_branch regression: pass");
        else
            $display("register_alu_with_flags_and_branch regression: fail");
        $finish;
    end

endmodule
